### design/jlca_pkg.sv
package jlca_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int MAX_JUMPS    = 256;
   localparam int ADDR_BITS    = 16;

   localparam int FIELD_ADDR_W = 16;
   localparam int KIND_W       = 3;
   localparam int STATUS_W     = 3;
   localparam int CHAN_OUT_W   = 4;
   localparam int CSR_INDEX_W  = 4;
   localparam int KEY_W        = 2 * FIELD_ADDR_W;

   localparam int CHAN_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int JMP_IDX_W   = (MAX_JUMPS > 1) ? $clog2(MAX_JUMPS) : 1;
   localparam int JMP_CNT_W   = $clog2(MAX_JUMPS + 1);

   typedef enum logic [STATUS_W-1:0] {
      STAT_PLACED     = 3'd0,
      STAT_DUPLICATE  = 3'd1,
      STAT_OUT_WINDOW = 3'd2,
      STAT_NO_CHANNEL = 3'd3,
      STAT_TABLE_FULL = 3'd4
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WINDOW_LOW  = 4'd0,
      REG_WINDOW_HIGH = 4'd1
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DUP,
      ST_SCAN,
      ST_SCAN_END,
      ST_PICK,
      ST_MARK,
      ST_MARK_END,
      ST_DONE
   } state_type;

   // Commands from the sequencer to the pair table.
   typedef struct packed {
      logic             search;
      logic             append;
      logic [KEY_W-1:0] key;
   } pt_cmd_type;

   // Status returned by the pair table.
   typedef struct packed {
      logic done;
      logic found;
      logic full;
   } pt_stat_type;

endpackage

### design/jlca_pair_table.sv
// Table of source and target pairs already placed, searched one entry per cycle.
module jlca_pair_table (
   input  logic                 clock,
   input  logic                 reset,
   input  jlca_pkg::pt_cmd_type cmd,
   output jlca_pkg::pt_stat_type stat
);

   logic [jlca_pkg::KEY_W-1:0]     pair_mem [jlca_pkg::MAX_JUMPS];

   logic [jlca_pkg::JMP_CNT_W-1:0] count_ff, count_in;
   logic [jlca_pkg::JMP_CNT_W-1:0] idx_ff, idx_in;
   logic                           searching_ff, searching_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic                           hit_ff, hit_in;
   logic [jlca_pkg::KEY_W-1:0]     rd_data_ff;
   logic                           issue;
   logic                           done;

   assign issue = searching_ff && (idx_ff != count_ff);
   assign done  = searching_ff && (idx_ff == count_ff) && !rd_vld_ff;

   always_comb begin
      count_in     = count_ff;
      idx_in       = idx_ff;
      searching_in = searching_ff;
      rd_vld_in    = issue;
      hit_in       = hit_ff;
      if (rd_vld_ff && (rd_data_ff == cmd.key)) begin
         hit_in = 1'b1;
      end
      if (issue) begin
         idx_in = idx_ff + 1'b1;
      end
      if (done) begin
         searching_in = 1'b0;
      end
      if (cmd.search) begin
         searching_in = 1'b1;
         idx_in       = '0;
         rd_vld_in    = 1'b0;
         hit_in       = 1'b0;
      end
      if (cmd.append) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         searching_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         searching_ff <= searching_in;
         rd_vld_ff    <= rd_vld_in;
         hit_ff       <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append) begin
         pair_mem[count_ff[jlca_pkg::JMP_IDX_W-1:0]] <= cmd.key;
      end
      rd_data_ff <= pair_mem[idx_ff[jlca_pkg::JMP_IDX_W-1:0]];
   end

   assign stat.done  = done;
   assign stat.found = hit_ff;
   assign stat.full  = (count_ff == jlca_pkg::JMP_CNT_W'(jlca_pkg::MAX_JUMPS));

endmodule

### design/jump_line_channel_allocator_top.sv
// Channel    | Direction | Handshake            | Payload
// req_       | in        | req_valid/req_stall  | source_addr, target_addr, jump_kind
// rsp_       | out       | rsp_valid/rsp_stall  | status, assigned_channel,
//            |           |                      | highest_channel, kind_echo
// csr_       | in        | csr_valid/csr_ready  | index, data (window_low, window_high)
//
// After reset the occupancy memory is cleared one address per cycle, over all 2^ADDR_BITS
// addresses (65536), and no request is taken until that pass ends.
// For a placed request the pair table is searched one entry per cycle, then the
// occupancy memory, read and written through separate ports, walks the span once to
// read and once more to mark. Rejected requests finish sooner.
// The block takes one request at a time; req_stall is high while it works.
// A finished response waits in an output register, so a new request is accepted
// while rsp_stall holds the previous response.
module jump_line_channel_allocator_top (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [jlca_pkg::FIELD_ADDR_W-1:0]   req_source_addr,
   input  logic [jlca_pkg::FIELD_ADDR_W-1:0]   req_target_addr,
   input  logic [jlca_pkg::KIND_W-1:0]         req_jump_kind,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [jlca_pkg::STATUS_W-1:0]       rsp_status,
   output logic [jlca_pkg::CHAN_OUT_W-1:0]     rsp_assigned_channel,
   output logic [jlca_pkg::CHAN_OUT_W-1:0]     rsp_highest_channel,
   output logic [jlca_pkg::KIND_W-1:0]         rsp_kind_echo,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [jlca_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [jlca_pkg::FIELD_ADDR_W-1:0]   csr_data
);

   localparam int AW = jlca_pkg::ADDR_BITS;
   localparam int CW = jlca_pkg::CHAN_W;
   localparam int NC = jlca_pkg::MAX_CHANNELS;
   localparam int FW = jlca_pkg::FIELD_ADDR_W;

   // Occupancy memory: one busy mask per address.
   logic [NC-1:0] busy_mem [2**AW];

   jlca_pkg::state_type  state_ff, state_in;
   jlca_pkg::status_type stat_ff, stat_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [AW-1:0]        lo_ff, lo_in;
   logic [AW-1:0]        hi_ff, hi_in;
   logic [FW-1:0]        src_ff, src_in;
   logic [FW-1:0]        dst_ff, dst_in;
   logic [jlca_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [NC-1:0]        acc_ff, acc_in;
   logic [CW-1:0]        chan_ff, chan_in;
   logic [CW-1:0]        max_ff, max_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [AW-1:0]        rd_addr_q_ff;
   logic [NC-1:0]        rd_data_ff;
   logic [FW-1:0]        win_lo_ff, win_lo_in;
   logic [FW-1:0]        win_hi_ff, win_hi_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   jlca_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [jlca_pkg::CHAN_OUT_W-1:0] rsp_chan_ff, rsp_chan_in;
   logic [jlca_pkg::CHAN_OUT_W-1:0] rsp_high_ff, rsp_high_in;
   logic [jlca_pkg::KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;

   logic                 req_take;
   logic                 out_window;
   logic [AW-1:0]        req_src_m;
   logic [AW-1:0]        req_dst_m;
   logic [CW-1:0]        free_chan;
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   logic [NC-1:0]        mem_wdata;
   logic [AW-1:0]        mem_raddr;
   logic                 rsp_free;
   logic [CW+jlca_pkg::CHAN_OUT_W-1:0] chan_ext;
   logic [CW+jlca_pkg::CHAN_OUT_W-1:0] max_ext;

   jlca_pkg::pt_cmd_type  pt_cmd;
   jlca_pkg::pt_stat_type pt_stat;

   jlca_pair_table u_pair_table (
      .clock (clock),
      .reset (reset),
      .cmd   (pt_cmd),
      .stat  (pt_stat)
   );

   assign req_stall = (state_ff != jlca_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // The window test uses the full 16-bit addresses; an empty window rejects all.
   assign out_window = (req_source_addr < win_lo_ff) || (req_source_addr > win_hi_ff) ||
                       (req_target_addr < win_lo_ff) || (req_target_addr > win_hi_ff);

   assign req_src_m = req_source_addr[AW-1:0];
   assign req_dst_m = req_target_addr[AW-1:0];

   // Lowest channel that is free along the whole span.
   always_comb begin
      free_chan = '0;
      for (int i = NC - 1; i >= 0; i--) begin
         if (!acc_ff[i]) begin
            free_chan = CW'(i);
         end
      end
   end

   assign chan_ext = {{jlca_pkg::CHAN_OUT_W{1'b0}}, chan_ff};
   assign max_ext  = {{jlca_pkg::CHAN_OUT_W{1'b0}}, max_ff};

   // Clearing pass writes zeros; marking writes back the mask read in the previous cycle.
   assign mem_we    = (state_ff == jlca_pkg::ST_CLEAR) ||
                      (((state_ff == jlca_pkg::ST_MARK) ||
                        (state_ff == jlca_pkg::ST_MARK_END)) && rd_vld_ff);
   assign mem_waddr = (state_ff == jlca_pkg::ST_CLEAR) ? addr_ff : rd_addr_q_ff;
   assign mem_wdata = (state_ff == jlca_pkg::ST_CLEAR) ? '0 :
                      (rd_data_ff | (NC'(1) << chan_ff));
   assign mem_raddr = addr_ff;

   always_comb begin
      state_in      = state_ff;
      stat_in       = stat_ff;
      addr_in       = addr_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      src_in        = src_ff;
      dst_in        = dst_ff;
      kind_in       = kind_ff;
      acc_in        = acc_ff;
      chan_in       = chan_ff;
      max_in        = max_ff;
      rd_vld_in     = 1'b0;
      win_lo_in     = win_lo_ff;
      win_hi_in     = win_hi_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_chan_in   = rsp_chan_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_kind_in   = rsp_kind_ff;
      pt_cmd.search = 1'b0;
      pt_cmd.append = 1'b0;
      pt_cmd.key    = {src_ff, dst_ff};

      if (csr_valid && csr_ready) begin
         case (csr_index)
            jlca_pkg::REG_WINDOW_LOW:  win_lo_in = csr_data;
            jlca_pkg::REG_WINDOW_HIGH: win_hi_in = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         jlca_pkg::ST_CLEAR: begin
            addr_in = addr_ff + 1'b1;
            if (addr_ff == {AW{1'b1}}) begin
               state_in = jlca_pkg::ST_IDLE;
            end
         end
         jlca_pkg::ST_IDLE: begin
            if (req_take) begin
               src_in  = req_source_addr;
               dst_in  = req_target_addr;
               kind_in = req_jump_kind;
               lo_in   = (req_src_m < req_dst_m) ? req_src_m : req_dst_m;
               hi_in   = (req_src_m < req_dst_m) ? req_dst_m : req_src_m;
               if (out_window) begin
                  stat_in  = jlca_pkg::STAT_OUT_WINDOW;
                  state_in = jlca_pkg::ST_DONE;
               end else begin
                  pt_cmd.search = 1'b1;
                  state_in      = jlca_pkg::ST_DUP;
               end
            end
         end
         jlca_pkg::ST_DUP: begin
            if (pt_stat.done) begin
               if (pt_stat.found) begin
                  stat_in  = jlca_pkg::STAT_DUPLICATE;
                  state_in = jlca_pkg::ST_DONE;
               end else if (pt_stat.full) begin
                  stat_in  = jlca_pkg::STAT_TABLE_FULL;
                  state_in = jlca_pkg::ST_DONE;
               end else begin
                  addr_in  = lo_ff;
                  acc_in   = '0;
                  state_in = jlca_pkg::ST_SCAN;
               end
            end
         end
         jlca_pkg::ST_SCAN: begin
            rd_vld_in = 1'b1;
            if (rd_vld_ff) begin
               acc_in = acc_ff | rd_data_ff;
            end
            if (addr_ff == hi_ff) begin
               state_in = jlca_pkg::ST_SCAN_END;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         jlca_pkg::ST_SCAN_END: begin
            acc_in   = acc_ff | rd_data_ff;
            state_in = jlca_pkg::ST_PICK;
         end
         jlca_pkg::ST_PICK: begin
            if (acc_ff == {NC{1'b1}}) begin
               stat_in  = jlca_pkg::STAT_NO_CHANNEL;
               state_in = jlca_pkg::ST_DONE;
            end else begin
               chan_in       = free_chan;
               pt_cmd.append = 1'b1;
               if (free_chan > max_ff) begin
                  max_in = free_chan;
               end
               addr_in  = lo_ff;
               state_in = jlca_pkg::ST_MARK;
            end
         end
         jlca_pkg::ST_MARK: begin
            rd_vld_in = 1'b1;
            if (addr_ff == hi_ff) begin
               state_in = jlca_pkg::ST_MARK_END;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         jlca_pkg::ST_MARK_END: begin
            stat_in  = jlca_pkg::STAT_PLACED;
            state_in = jlca_pkg::ST_DONE;
         end
         jlca_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_chan_in   = (stat_ff == jlca_pkg::STAT_PLACED) ?
                               chan_ext[jlca_pkg::CHAN_OUT_W-1:0] : '0;
               rsp_high_in   = max_ext[jlca_pkg::CHAN_OUT_W-1:0];
               rsp_kind_in   = kind_ff;
               state_in      = jlca_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jlca_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jlca_pkg::ST_CLEAR;
         addr_ff      <= '0;
         max_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         win_lo_ff    <= '0;
         win_hi_ff    <= {FW{1'b1}};
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         max_ff       <= max_in;
         rd_vld_ff    <= rd_vld_in;
         win_lo_ff    <= win_lo_in;
         win_hi_ff    <= win_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stat_ff       <= stat_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      src_ff        <= src_in;
      dst_ff        <= dst_in;
      kind_ff       <= kind_in;
      acc_ff        <= acc_in;
      chan_ff       <= chan_in;
      rd_addr_q_ff  <= mem_raddr;
      rsp_status_ff <= rsp_status_in;
      rsp_chan_ff   <= rsp_chan_in;
      rsp_high_ff   <= rsp_high_in;
      rsp_kind_ff   <= rsp_kind_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         busy_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= busy_mem[mem_raddr];
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_assigned_channel = rsp_chan_ff;
   assign rsp_highest_channel  = rsp_high_ff;
   assign rsp_kind_echo        = rsp_kind_ff;

   // The write-back of a marked address never collides with the read of the next one.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == jlca_pkg::ST_MARK) && rd_vld_ff) |-> (mem_waddr != mem_raddr))
      else $error("mark write-back collides with read address");

   // The span walk stays inside the span.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == jlca_pkg::ST_SCAN) || (state_ff == jlca_pkg::ST_MARK)) |->
      ((addr_ff >= lo_ff) && (addr_ff <= hi_ff)))
      else $error("span walk left its span");

   // Only a placed request carries a channel.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != jlca_pkg::STAT_PLACED)) |-> (rsp_assigned_channel == '0))
      else $error("rejected request reports a channel");

   // A new response is only loaded from the finishing state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> ($past(state_ff) == jlca_pkg::ST_DONE))
      else $error("response appeared outside the finishing state");

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int RESET_CYCLES     = 11;
   localparam int MAX_PAUSE        = 4;
   // The slowest request walks all 65536 addresses twice, after a clearing pass over all
   // of them; the limit leaves a wide margin over both.
   localparam int WATCHDOG_LIMIT   = 400000;
   localparam int DRAIN_CYCLES     = 600;
   localparam int JUMP_BUDGET      = 1970;
   localparam int PRESSURE_CAP     = 1200;
   localparam int PHASE_JUMPS      = 60;
   localparam int FULL_PHASE_JUMPS = 200;
   localparam int CLUSTER_MAX      = 24;

   typedef struct packed {
      jlca_pkg::status_type                  status;
      logic [jlca_pkg::CHAN_OUT_W-1:0]       channel;
      logic [jlca_pkg::CHAN_OUT_W-1:0]       highest;
      logic [jlca_pkg::KIND_W-1:0]           kind;
   } jump_outcome_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [jlca_pkg::FIELD_ADDR_W-1:0] req_source_addr = '0;
   logic [jlca_pkg::FIELD_ADDR_W-1:0] req_target_addr = '0;
   logic [jlca_pkg::KIND_W-1:0]       req_jump_kind = '0;

   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [jlca_pkg::STATUS_W-1:0]     rsp_status;
   logic [jlca_pkg::CHAN_OUT_W-1:0]   rsp_assigned_channel;
   logic [jlca_pkg::CHAN_OUT_W-1:0]   rsp_highest_channel;
   logic [jlca_pkg::KIND_W-1:0]       rsp_kind_echo;

   logic                              csr_valid = 1'b0;
   logic                              csr_ready;
   logic [jlca_pkg::CSR_INDEX_W-1:0]  csr_index = '0;
   logic [jlca_pkg::FIELD_ADDR_W-1:0] csr_data = '0;

   // Scoreboard state. The occupancy map starts with every channel free, as after reset.
   bit   [jlca_pkg::MAX_CHANNELS-1:0] busy_map [0:(1 << jlca_pkg::ADDR_BITS)-1];
   logic [jlca_pkg::KEY_W-1:0]        pair_log [0:jlca_pkg::MAX_JUMPS-1];
   int                                pairs_held = 0;
   logic [jlca_pkg::CHAN_OUT_W-1:0]   top_channel = '0;
   logic [jlca_pkg::FIELD_ADDR_W-1:0] win_low = '0;
   logic [jlca_pkg::FIELD_ADDR_W-1:0] win_high = '1;

   jump_outcome_type outcomes_due [$];
   int               mismatches = 0;
   int               jumps_sent = 0;
   int               quiet_cycles = 0;
   int               stall_left = 0;
   // When set, neither side pauses, so requests and responses run back to back.
   bit               steady = 1'b0;

   jump_line_channel_allocator_top dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_source_addr      (req_source_addr),
      .req_target_addr      (req_target_addr),
      .req_jump_kind        (req_jump_kind),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_status           (rsp_status),
      .rsp_assigned_channel (rsp_assigned_channel),
      .rsp_highest_channel  (rsp_highest_channel),
      .rsp_kind_echo        (rsp_kind_echo),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   always #10 clock = ~clock;

   function automatic int pause_cycles();
      return steady ? 0 : $urandom_range(0, MAX_PAUSE);
   endfunction

   function automatic logic [jlca_pkg::FIELD_ADDR_W-1:0] rand_addr(int unsigned value);
      return jlca_pkg::FIELD_ADDR_W'(value);
   endfunction

   function automatic logic [jlca_pkg::KIND_W-1:0] rand_kind();
      return jlca_pkg::KIND_W'($urandom_range(0, 7));
   endfunction

   function automatic bit rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   // Works out the response to one jump and applies its effect to the scoreboard state.
   // The checks run in the block's order: window, duplicate pair, full table, channels.
   function automatic jump_outcome_type place_jump(
         logic [jlca_pkg::FIELD_ADDR_W-1:0] src,
         logic [jlca_pkg::FIELD_ADDR_W-1:0] dst,
         logic [jlca_pkg::KIND_W-1:0] kind);
      jump_outcome_type                  outcome;
      logic [jlca_pkg::KEY_W-1:0]        key;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] lo;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] hi;
      logic [jlca_pkg::MAX_CHANNELS-1:0] taken;
      bit                                known;
      int                                ch;
      key = {src, dst};
      outcome.channel = '0;
      outcome.kind = kind;
      known = 1'b0;
      for (int i = 0; i < pairs_held; i++) begin
         if (pair_log[i] == key) begin
            known = 1'b1;
         end
      end
      if (src < win_low || src > win_high || dst < win_low || dst > win_high) begin
         outcome.status = jlca_pkg::STAT_OUT_WINDOW;
      end else if (known) begin
         outcome.status = jlca_pkg::STAT_DUPLICATE;
      end else if (pairs_held >= jlca_pkg::MAX_JUMPS) begin
         outcome.status = jlca_pkg::STAT_TABLE_FULL;
      end else begin
         lo = (src < dst) ? src : dst;
         hi = (src < dst) ? dst : src;
         taken = '0;
         for (int a = lo; a <= hi; a++) begin
            taken |= busy_map[a];
         end
         if (&taken) begin
            outcome.status = jlca_pkg::STAT_NO_CHANNEL;
         end else begin
            ch = 0;
            while (taken[ch]) begin
               ch++;
            end
            for (int a = lo; a <= hi; a++) begin
               busy_map[a][ch] = 1'b1;
            end
            pair_log[pairs_held] = key;
            pairs_held++;
            if (ch > top_channel) begin
               top_channel = jlca_pkg::CHAN_OUT_W'(ch);
            end
            outcome.status = jlca_pkg::STAT_PLACED;
            outcome.channel = jlca_pkg::CHAN_OUT_W'(ch);
         end
      end
      outcome.highest = top_channel;
      return outcome;
   endfunction

   task automatic report_mismatch(string field, logic [15:0] got, logic [15:0] want);
      mismatches++;
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, field, got, want);
   endtask

   // Presents one request after a random pause and predicts its response once accepted.
   // The valid stays high on return, so a request that follows at once goes out back to
   // back; settle() or the next pause lowers it.
   task automatic send_jump(input logic [jlca_pkg::FIELD_ADDR_W-1:0] src,
                            input logic [jlca_pkg::FIELD_ADDR_W-1:0] dst,
                            input logic [jlca_pkg::KIND_W-1:0] kind);
      int gap;
      gap = pause_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_source_addr <= src;
      req_target_addr <= dst;
      req_jump_kind   <= kind;
      do @(posedge clock); while (req_stall !== 1'b0);
      outcomes_due.push_back(place_jump(src, dst, kind));
      jumps_sent++;
   endtask

   // Stops sending and waits until every predicted response has come back. Every request
   // gives exactly one response, so the block is idle once the queue is empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (outcomes_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [jlca_pkg::CSR_INDEX_W-1:0] index,
                            input logic [jlca_pkg::FIELD_ADDR_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (index == jlca_pkg::REG_WINDOW_LOW) begin
         win_low = data;
      end else if (index == jlca_pkg::REG_WINDOW_HIGH) begin
         win_high = data;
      end
   endtask

   // Writes both window registers, first a register index that does not exist if asked.
   // Only called while no request is outstanding.
   task automatic set_window(input logic [jlca_pkg::FIELD_ADDR_W-1:0] lo,
                             input logic [jlca_pkg::FIELD_ADDR_W-1:0] hi, input bit stray);
      if (stray) begin
         write_csr(jlca_pkg::CSR_INDEX_W'($urandom_range(jlca_pkg::REG_WINDOW_HIGH + 1,
                                                         (1 << jlca_pkg::CSR_INDEX_W) - 1)),
                   rand_addr($urandom));
      end
      write_csr(jlca_pkg::REG_WINDOW_LOW, lo);
      write_csr(jlca_pkg::REG_WINDOW_HIGH, hi);
      csr_valid <= 1'b0;
   endtask

   // Overlapping jumps with ascending lower ends: every jump of the cluster covers the
   // two addresses in its middle, so a long cluster runs out of channels.
   task automatic send_cluster(input int size);
      logic [jlca_pkg::FIELD_ADDR_W-1:0] base;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] src;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] dst;
      base = rand_addr($urandom_range(win_high - 48, win_low));
      for (int i = 0; i < size; i++) begin
         src = rand_addr(base + i);
         dst = rand_addr(base + CLUSTER_MAX + $urandom_range(0, CLUSTER_MAX - 1));
         if ($urandom_range(0, 3) == 0) begin
            send_jump(dst, src, rand_kind());
         end else begin
            send_jump(src, dst, rand_kind());
         end
      end
   endtask

   task automatic send_known_pair();
      logic [jlca_pkg::KEY_W-1:0] key;
      key = pair_log[$urandom_range(0, pairs_held - 1)];
      send_jump(key[jlca_pkg::KEY_W-1:jlca_pkg::FIELD_ADDR_W],
                key[jlca_pkg::FIELD_ADDR_W-1:0], rand_kind());
   endtask

   task automatic test_kinds_and_extremes();
      steady = 1'b0;
      set_window(16'h0000, 16'hFFFF, 1'b1);
      send_jump(16'h0000, 16'h0000, 3'd0);
      send_jump(16'hFFFF, 16'hFFFF, 3'd1);
      send_jump(16'h0000, 16'h0000, 3'd2);
      // The whole address space, given with source above target.
      send_jump(16'hFFFF, 16'h0000, 3'd3);
      send_jump(16'h00FF, 16'h0100, 3'd4);
      send_jump(16'h0100, 16'h00FF, 3'd5);
      send_jump(16'h1234, 16'h1234, 3'd6);
      send_jump(16'h5555, 16'hAAAA, 3'd7);
   endtask

   task automatic test_window_checks();
      settle();
      set_window(16'h1000, 16'h1FFF, 1'b1);
      send_jump(16'h0FFF, 16'h1000, 3'd1);
      send_jump(16'h1000, 16'h2000, 3'd2);
      send_jump(16'h1FFF, 16'h1000, 3'd3);
      // A recorded pair outside the window is reported as out of window, not duplicate.
      send_jump(16'h0000, 16'h0000, 3'd4);
      send_jump(16'h1FFF, 16'h1000, 3'd0);
      settle();
      // An empty window takes nothing.
      set_window(16'h2000, 16'h1FFF, 1'b0);
      send_jump(16'h2000, 16'h2000, 3'd1);
      send_jump(16'h1FFF, 16'h1FFF, 3'd2);
      settle();
      set_window(16'h3000, 16'h3000, 1'b1);
      send_jump(16'h3000, 16'h3000, 3'd3);
      send_jump(16'h3000, 16'h3001, 3'd4);
      send_jump(16'h2FFF, 16'h3000, 3'd5);
      settle();
      set_window(16'h0000, 16'hFFFF, 1'b1);
      send_jump(16'h1000, 16'h1001, 3'd6);
   endtask

   // Fills the channels and the pair table with mostly well-formed clusters, mixed with
   // repeated pairs, jumps outside the window and a few longer spans.
   task automatic test_channel_pressure();
      int                                phase_jumps;
      int                                pick;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] lo;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] src;
      while (pairs_held < jlca_pkg::MAX_JUMPS && jumps_sent < PRESSURE_CAP) begin
         settle();
         steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 3) == 0) begin
            set_window(16'h0000, 16'hFFFF, rand_bit());
         end else begin
            lo = rand_addr($urandom_range(0, 16'hE000));
            set_window(lo, rand_addr(lo + $urandom_range(16'h0800, 16'h1FFF)), rand_bit());
         end
         phase_jumps = 0;
         while (phase_jumps < PHASE_JUMPS && pairs_held < jlca_pkg::MAX_JUMPS) begin
            pick = $urandom_range(0, 99);
            if (pick < 10 && pairs_held > 0) begin
               send_known_pair();
               phase_jumps++;
            end else if (pick < 20) begin
               // Just outside the window where there is room, else a short jump anywhere.
               src = (win_low != 0) ? rand_addr(win_low - 1) : rand_addr(win_high + 1);
               send_jump(src, rand_addr(src ^ $urandom_range(0, 63)), rand_kind());
               phase_jumps++;
            end else if (pick < 24) begin
               src = rand_addr($urandom_range(win_high - 1024, win_low));
               send_jump(src, rand_addr(src + $urandom_range(64, 1023)), rand_kind());
               phase_jumps++;
            end else begin
               pick = $urandom_range(1, CLUSTER_MAX);
               send_cluster(pick);
               phase_jumps += pick;
            end
         end
      end
   endtask

   // Once the pair table is full nothing more is placed; the window and duplicate checks
   // still decide between their statuses, under windows of every shape.
   task automatic test_full_table();
      int                                phase_jumps;
      int                                pick;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] lo;
      logic [jlca_pkg::FIELD_ADDR_W-1:0] hi;
      while (jumps_sent < JUMP_BUDGET) begin
         settle();
         steady = ($urandom_range(0, 3) == 0);
         lo = rand_addr($urandom);
         hi = rand_addr($urandom);
         case ($urandom_range(0, 3))
            0: begin
               set_window(16'h0000, 16'hFFFF, rand_bit());
            end
            1: begin
               set_window(lo, lo, rand_bit());
            end
            2: begin
               set_window(lo, hi, rand_bit());
            end
            default: begin
               set_window((lo < hi) ? lo : hi, (lo < hi) ? hi : lo, rand_bit());
            end
         endcase
         phase_jumps = 0;
         while (phase_jumps < FULL_PHASE_JUMPS && jumps_sent < JUMP_BUDGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 35 && pairs_held > 0) begin
               send_known_pair();
            end else if (pick < 70) begin
               send_jump(rand_addr($urandom), rand_addr($urandom), rand_kind());
            end else if (pick < 80) begin
               send_jump(win_low, win_high, rand_kind());
            end else if (pick < 90) begin
               send_jump(rand_addr(win_low - 1), win_low, rand_kind());
            end else begin
               send_jump(win_high, rand_addr(win_high + 1), rand_kind());
            end
            phase_jumps++;
         end
      end
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_kinds_and_extremes();
      test_window_checks();
      test_channel_pressure();
      test_full_table();
      settle();
      // Any response that shows up now has no request behind it and is flagged.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Response checker and response-side pauses. After each accepted response a pause
   // length is drawn; rsp_stall then holds off the next response while that length counts down.
   always @(posedge clock) begin
      jump_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("response with no request outstanding, status",
                            16'(rsp_status), 16'd0);
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", 16'(rsp_status), 16'(want.status));
            end
            if (rsp_assigned_channel !== want.channel) begin
               report_mismatch("assigned_channel", 16'(rsp_assigned_channel),
                               16'(want.channel));
            end
            if (rsp_highest_channel !== want.highest) begin
               report_mismatch("highest_channel", 16'(rsp_highest_channel),
                               16'(want.highest));
            end
            if (rsp_kind_echo !== want.kind) begin
               report_mismatch("kind_echo", 16'(rsp_kind_echo), 16'(want.kind));
            end
         end
         stall_left = pause_cycles();
         rsp_stall <= (stall_left != 0);
      end else if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b1) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   // Watchdog: counts cycles in which no channel moves anything.
   always @(posedge clock) begin
      if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall) ||
          (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

endmodule
